// ===== hw/rtl/afolp_pkg.sv =====
package afolp_pkg;

  // Fixed field widths
  localparam int FILT_W = 32;
  localparam int COEF_W = 9;
  localparam int DIR_W  = 2;
  localparam int CNT_W  = 8;
  localparam int THR_W  = 23;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 23;

  // Coefficient weight is out of 256: product is scaled down by this shift
  localparam int COEF_SHIFT = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = 8'hff;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_FIXED_MODE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_INITIAL    = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_STEP       = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_MAX        = 3'd3;
  localparam logic [IDX_W-1:0] REG_DIR_THRESHOLD   = 3'd4;
  localparam logic [IDX_W-1:0] REG_ACCEL_THRESHOLD = 3'd5;
  localparam logic [IDX_W-1:0] REG_DAMPING_LIMIT   = 3'd6;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // Samples seen, saturating
  typedef enum logic [1:0] {
    PHASE_EMPTY  = 2'd0,
    PHASE_FIRST  = 2'd1,
    PHASE_SECOND = 2'd2,
    PHASE_RUN    = 2'd3
  } phase_t;

  typedef struct packed {
    logic              fixed_mode;
    logic [COEF_W-1:0] coef_initial;
    logic [COEF_W-1:0] coef_step;
    logic [COEF_W-1:0] coef_max;
    logic [THR_W-1:0]  dir_threshold;
    logic [THR_W-1:0]  accel_threshold;
    logic [CNT_W-1:0]  damping_limit;
  } cfg_t;

  typedef struct packed {
    phase_t                   phase;
    logic signed [FILT_W-1:0] prev_output;
    dir_t                     prev_direction;
    logic [COEF_W-1:0]        prev_coef;
    logic [CNT_W-1:0]         damping_count;
  } state_t;

  typedef struct packed {
    logic signed [FILT_W-1:0] filtered;
    dir_t                     direction;
    logic [COEF_W-1:0]        coef_used;
  } result_t;

endpackage

// ===== hw/rtl/adaptive_first_order_lowpass.sv =====
// Channel   | Direction | Handshake             | Payload
// sample    | in        | sample_valid/_stall   | sample
// result    | out       | result_valid/_stall   | filtered, direction, coef_used
// cfg       | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One sample is taken every cycle while the input does not stall; the input register
// takes the word, and the result register then takes the single filter step (one
// subtract, one multiply, one add) once the result slot frees.
// Reset clears the filter state and both valid flags and sets the configuration to its defaults.
// The input stalls only while a result is held and result_stall is high.
module adaptive_first_order_lowpass #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int FRAC_BITS    = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [afolp_pkg::FILT_W-1:0] filtered,
  output logic [afolp_pkg::DIR_W-1:0]         direction,
  output logic [afolp_pkg::COEF_W-1:0]        coef_used,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [afolp_pkg::IDX_W-1:0]         cfg_index,
  input  logic [afolp_pkg::DATA_W-1:0]        cfg_data
);

  afolp_pkg::cfg_t    cfg;
  afolp_pkg::state_t  st;
  afolp_pkg::state_t  st_next;
  afolp_pkg::result_t res;

  logic                          s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample;
  logic                          advance;

  afolp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  afolp_step #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_step (
    .sample  (s1_sample),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  // Move the held word into the result register when that slot frees
  assign advance      = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sample_stall) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1_sample <= sample;
    end
  end

  // Filter state advances with each word processed
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase          <= afolp_pkg::PHASE_EMPTY;
      st.prev_output    <= '0;
      st.prev_direction <= afolp_pkg::DIR_NONE;
      st.prev_coef      <= '0;
      st.damping_count  <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered  <= res.filtered;
      direction <= res.direction;
      coef_used <= res.coef_used;
    end
  end

endmodule

// ===== hw/rtl/afolp_cfg.sv =====
module afolp_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [afolp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [afolp_pkg::DATA_W-1:0]  cfg_data,
  output afolp_pkg::cfg_t               cfg
);

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Write the addressed register, masked to its width; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fixed_mode      <= 1'b0;
      cfg.coef_initial    <= 9'd32;
      cfg.coef_step       <= 9'd8;
      cfg.coef_max        <= 9'd256;
      cfg.dir_threshold   <= '0;
      cfg.accel_threshold <= '0;
      cfg.damping_limit   <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        afolp_pkg::REG_FIXED_MODE:      cfg.fixed_mode      <= cfg_data[0];
        afolp_pkg::REG_COEF_INITIAL:    cfg.coef_initial    <= cfg_data[afolp_pkg::COEF_W-1:0];
        afolp_pkg::REG_COEF_STEP:       cfg.coef_step       <= cfg_data[afolp_pkg::COEF_W-1:0];
        afolp_pkg::REG_COEF_MAX:        cfg.coef_max        <= cfg_data[afolp_pkg::COEF_W-1:0];
        afolp_pkg::REG_DIR_THRESHOLD:   cfg.dir_threshold   <= cfg_data[afolp_pkg::THR_W-1:0];
        afolp_pkg::REG_ACCEL_THRESHOLD: cfg.accel_threshold <= cfg_data[afolp_pkg::THR_W-1:0];
        afolp_pkg::REG_DAMPING_LIMIT:   cfg.damping_limit   <= cfg_data[afolp_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/afolp_step.sv =====
module afolp_step #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int FRAC_BITS    = 8
) (
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  afolp_pkg::state_t              st,
  input  afolp_pkg::cfg_t                cfg,
  output afolp_pkg::state_t              st_next,
  output afolp_pkg::result_t             res
);

  localparam int XW = SAMPLE_WIDTH + FRAC_BITS;
  localparam int DW = ((XW > afolp_pkg::FILT_W) ? XW : afolp_pkg::FILT_W) + 1;
  localparam int PW = DW + afolp_pkg::COEF_W + 1;
  localparam int TW = afolp_pkg::THR_W + FRAC_BITS;
  localparam int CW = (DW > TW) ? DW : TW;

  localparam logic signed [PW-1:0] SAT_HI =
    {{(PW - afolp_pkg::FILT_W){1'b0}}, 1'b0, {(afolp_pkg::FILT_W - 1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_LO =
    {{(PW - afolp_pkg::FILT_W){1'b1}}, 1'b1, {(afolp_pkg::FILT_W - 1){1'b0}}};

  function automatic logic signed [afolp_pkg::FILT_W-1:0] sat_out(
    input logic signed [PW-1:0] v
  );
    logic signed [afolp_pkg::FILT_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[afolp_pkg::FILT_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[afolp_pkg::FILT_W-1:0];
    end else begin
      r = v[afolp_pkg::FILT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [afolp_pkg::CNT_W-1:0] count_inc(
    input logic [afolp_pkg::CNT_W-1:0] c
  );
    return (c == afolp_pkg::COUNT_MAX) ? c : c + 8'd1;
  endfunction

  logic signed [DW-1:0]           x_ext;
  logic signed [DW-1:0]           base_ext;
  logic signed [DW-1:0]           diff;
  logic [DW-1:0]                  mag;
  logic [CW-1:0]                  dead_zone;
  logic [CW-1:0]                  accel;
  logic                           moved;
  logic                           accel_hit;
  afolp_pkg::dir_t                dir;
  logic [afolp_pkg::COEF_W:0]     coef_sum;
  logic [afolp_pkg::COEF_W-1:0]   coef;
  logic [afolp_pkg::CNT_W-1:0]    count_once;
  logic [afolp_pkg::CNT_W-1:0]    count_twice;
  logic signed [PW-1:0]           prod;
  logic signed [PW-1:0]           y_sum;

  // Difference against the last output, and its magnitude
  assign x_ext    = DW'(sample) <<< FRAC_BITS;
  assign base_ext = DW'(st.prev_output);
  assign diff     = x_ext - base_ext;
  assign mag      = diff[DW-1] ? $unsigned(-diff) : $unsigned(diff);

  // Classify against the dead zone and the acceleration threshold
  assign dead_zone = CW'(cfg.dir_threshold) << FRAC_BITS;
  assign accel     = CW'(cfg.accel_threshold) << FRAC_BITS;
  assign moved     = CW'(mag) > dead_zone;
  assign accel_hit = CW'(mag) > accel;
  assign dir       = !moved ? afolp_pkg::DIR_NONE :
                     diff[DW-1] ? afolp_pkg::DIR_DOWN : afolp_pkg::DIR_UP;

  // Ramp candidates
  assign coef_sum    = {1'b0, st.prev_coef} + {1'b0, cfg.coef_step};
  assign count_once  = count_inc(st.damping_count);
  assign count_twice = accel_hit ? count_inc(count_once) : count_once;

  // Filter update: floor of diff * coef / 256 by arithmetic shift
  assign prod  = diff * $signed({1'b0, coef});
  assign y_sum = PW'(base_ext) + (prod >>> afolp_pkg::COEF_SHIFT);

  // Choose coefficient, output and next state by phase
  always_comb begin
    coef                  = cfg.coef_initial;
    st_next.damping_count = st.damping_count;
    st_next.prev_direction = dir;
    res.direction         = dir;
    res.filtered          = sat_out(PW'(x_ext));

    unique case (st.phase)
      afolp_pkg::PHASE_EMPTY: begin
        st_next.prev_direction = afolp_pkg::DIR_NONE;
        res.direction          = afolp_pkg::DIR_NONE;
      end
      afolp_pkg::PHASE_FIRST: begin
      end
      afolp_pkg::PHASE_SECOND, afolp_pkg::PHASE_RUN: begin
        if (!cfg.fixed_mode) begin
          if (dir == st.prev_direction) begin
            coef                  = st.prev_coef;
            st_next.damping_count = count_twice;
            if (count_twice >= cfg.damping_limit) begin
              coef = (coef_sum >= {1'b0, cfg.coef_max}) ?
                     cfg.coef_max : coef_sum[afolp_pkg::COEF_W-1:0];
              st_next.damping_count = '0;
            end
          end else begin
            st_next.damping_count = '0;
          end
        end
        if (dir != afolp_pkg::DIR_NONE) begin
          res.filtered = sat_out(y_sum);
        end else begin
          res.filtered = st.prev_output;
        end
      end
      default: begin
      end
    endcase

    st_next.phase = (st.phase == afolp_pkg::PHASE_RUN) ?
                    afolp_pkg::PHASE_RUN : afolp_pkg::phase_t'(st.phase + 2'd1);
    st_next.prev_output = res.filtered;
    st_next.prev_coef   = coef;
    res.coef_used       = coef;
  end

endmodule

// ===== hw/rtl/afolp_checker.sv =====
module afolp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_stall,
  input logic                                result_valid,
  input logic                                result_stall,
  input logic signed [afolp_pkg::FILT_W-1:0] filtered,
  input logic [afolp_pkg::DIR_W-1:0]         direction,
  input logic [afolp_pkg::COEF_W-1:0]        coef_used
);

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // Input back-pressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (result_valid && result_stall))
    else $error("sample_stall without a stalled result");

  // A stalled result holds its word
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(filtered) && $stable(direction) && $stable(coef_used)))
    else $error("stalled result changed");

  // Direction code is none, up or down
  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (direction == afolp_pkg::DIR_NONE || direction == afolp_pkg::DIR_UP ||
                      direction == afolp_pkg::DIR_DOWN))
    else $error("bad direction code");

endmodule

bind adaptive_first_order_lowpass afolp_checker u_checker (.*);
